[rtl/radt_pkg.sv]
// Shared types and constants for the row adaptive dual threshold binarizer.
`timescale 1ns / 1ps

package radt_pkg;

   localparam int PIXEL_W = 8;
   localparam int GAIN_W = 17;
   localparam int RECIP_W = 25;
   localparam int FRAC_SHIFT = 16;
   localparam int MEAN_W = 16;
   localparam int THR_W = 18;
   localparam int GAIN_PROD_W = GAIN_W + MEAN_W;

   localparam int REG_INDEX_W = 3;
   localparam logic [REG_INDEX_W-1:0] REG_LOW_OFFSET = 3'd0;
   localparam logic [REG_INDEX_W-1:0] REG_GAIN_Q16 = 3'd1;
   localparam logic [REG_INDEX_W-1:0] REG_MIN_RISE = 3'd2;
   localparam logic [REG_INDEX_W-1:0] REG_MAX_RISE = 3'd3;
   localparam logic [REG_INDEX_W-1:0] REG_CEILING = 3'd4;

   localparam logic [PIXEL_W-1:0] LOW_OFFSET_RESET = 8'd2;
   localparam logic [GAIN_W-1:0] GAIN_Q16_RESET = 17'd69468;
   localparam logic [PIXEL_W-1:0] MIN_RISE_RESET = 8'd2;
   localparam logic [PIXEL_W-1:0] MAX_RISE_RESET = 8'd8;
   localparam logic [PIXEL_W-1:0] CEILING_RESET = 8'd230;

   typedef enum logic [1:0] {
      FRONT_STREAM,
      FRONT_ALIGN,
      FRONT_FLUSH
   } front_state_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] low_offset;
      logic [GAIN_W-1:0]  gain_q16;
      logic [PIXEL_W-1:0] min_rise;
      logic [PIXEL_W-1:0] max_rise;
      logic [PIXEL_W-1:0] ceiling;
   } cfg_type;

endpackage

[rtl/radt_front.sv]
// Front end: pixel window, running sums and row-end flush sequencing into threshold jobs.
`timescale 1ns / 1ps

module radt_front
   import radt_pkg::*;
#(
   parameter int HALF_WINDOW = 12
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              req_valid,
   output logic                                              req_ready,
   input  logic [PIXEL_W-1:0]                                req_pixel_value,
   input  logic                                              req_row_end,
   input  logic                                              queue_full,
   output logic                                              job_push,
   output logic [$clog2((2*HALF_WINDOW+1)*255+1)-1:0]        job_sum,
   output logic [$clog2(2*HALF_WINDOW+2)-1:0]                job_n,
   output logic [PIXEL_W-1:0]                                job_pixel,
   output logic                                              job_done
);

   localparam int WinDepth = 2 * HALF_WINDOW + 1;
   localparam int CNT_W = $clog2(WinDepth + 1);
   localparam int SUM_W = $clog2(WinDepth * 255 + 1);
   localparam int K_W = $clog2(HALF_WINDOW + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WinDepth);
   localparam logic [CNT_W-1:0] CNT_HALF = CNT_W'(HALF_WINDOW);
   localparam logic [K_W-1:0] K_HALF = K_W'(HALF_WINDOW);
   localparam logic [K_W-1:0] K_ONE = K_W'(1);

   front_state_type     state_ff, state_in;
   logic [PIXEL_W-1:0]  store_ff [0:WinDepth-1];
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [SUM_W-1:0]    fs_ff, fs_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [K_W-1:0]      k_ff, k_in;
   logic [K_W-1:0]      align_ff, align_in;

   logic                accept;
   logic [PIXEL_W-1:0]  drop;
   logic [SUM_W-1:0]    acc_new;
   logic [CNT_W-1:0]    n_new;
   logic                normal;
   logic [K_W-1:0]      pend;
   logic [K_W-1:0]      align_new;
   logic                flush_sub;
   logic [SUM_W-1:0]    flush_sum;
   logic [CNT_W-1:0]    flush_n;
   logic                shift_en;
   logic [PIXEL_W-1:0]  shift_in;

   assign accept = req_valid && req_ready;
   assign drop = (cnt_ff == CNT_FULL) ? store_ff[WinDepth-1] : '0;
   assign acc_new = acc_ff + SUM_W'(req_pixel_value) - SUM_W'(drop);
   assign n_new = (cnt_ff == CNT_FULL) ? CNT_FULL : cnt_ff + 1'b1;
   assign normal = (cnt_ff >= CNT_HALF);
   assign pend = normal ? K_HALF : K_W'(n_new);
   assign align_new = K_HALF - pend;
   assign flush_sub = (CNT_W'(k_ff) + CNT_HALF) < n_ff;
   assign flush_sum = fs_ff - (flush_sub ? SUM_W'(store_ff[WinDepth-1]) : '0);
   assign flush_n = flush_sub ? (CNT_W'(k_ff) + CNT_HALF) : n_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FRONT_STREAM: begin
            if (accept && req_row_end) begin
               state_in = (align_new != '0) ? FRONT_ALIGN : FRONT_FLUSH;
            end
         end
         FRONT_ALIGN: begin
            if (align_ff == K_ONE) begin
               state_in = FRONT_FLUSH;
            end
         end
         FRONT_FLUSH: begin
            if (!queue_full && k_ff == K_ONE) begin
               state_in = FRONT_STREAM;
            end
         end
         default: state_in = FRONT_STREAM;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      job_push = 1'b0;
      job_sum = acc_new;
      job_n = n_new;
      job_pixel = store_ff[HALF_WINDOW-1];
      job_done = 1'b0;
      shift_en = 1'b0;
      shift_in = '0;
      case (state_ff)
         FRONT_STREAM: begin
            req_ready = !queue_full;
            job_push = accept && normal;
            shift_en = accept;
            shift_in = req_pixel_value;
         end
         FRONT_ALIGN: begin
            shift_en = 1'b1;
         end
         FRONT_FLUSH: begin
            job_push = !queue_full;
            job_sum = flush_sum;
            job_n = flush_n;
            job_done = (k_ff == K_ONE);
            shift_en = !queue_full;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      fs_in = fs_ff;
      n_in = n_ff;
      k_in = k_ff;
      align_in = align_ff;
      if (accept) begin
         if (req_row_end) begin
            cnt_in = '0;
            acc_in = '0;
            fs_in = acc_new;
            n_in = n_new;
            k_in = pend;
            align_in = align_new;
         end else begin
            cnt_in = n_new;
            acc_in = acc_new;
         end
      end
      if (state_ff == FRONT_ALIGN) begin
         align_in = align_ff - 1'b1;
      end
      if (state_ff == FRONT_FLUSH && job_push) begin
         fs_in = flush_sum;
         k_in = k_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_STREAM;
         cnt_ff <= '0;
         acc_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      fs_ff <= fs_in;
      n_ff <= n_in;
      k_ff <= k_in;
      align_ff <= align_in;
      if (shift_en) begin
         store_ff[0] <= shift_in;
         for (int i = 1; i < WinDepth; i++) begin
            store_ff[i] <= store_ff[i-1];
         end
      end
   end

endmodule

[rtl/radt_queue.sv]
// Small first-in first-out queue of threshold jobs between the front and back ends.
`timescale 1ns / 1ps

module radt_queue
   import radt_pkg::*;
#(
   parameter int DEPTH = 4,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

   logic [DATA_W-1:0]  entry_ff [0:DEPTH-1];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full = (count_ff == COUNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/radt_back.sv]
// Back end: mean, dual thresholds and hysteresis decision in a stalling pipeline.
`timescale 1ns / 1ps

module radt_back
   import radt_pkg::*;
#(
   parameter int HALF_WINDOW = 12
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  cfg_type                                    cfg,
   input  logic                                       job_valid,
   input  logic [$clog2((2*HALF_WINDOW+1)*255+1)-1:0] job_sum,
   input  logic [$clog2(2*HALF_WINDOW+2)-1:0]         job_n,
   input  logic [PIXEL_W-1:0]                         job_pixel,
   input  logic                                       job_done,
   output logic                                       job_pop,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic                                       rsp_mask_bit,
   output logic                                       rsp_row_done
);

   localparam int WinDepth = 2 * HALF_WINDOW + 1;
   localparam int SUM_W = $clog2(WinDepth * 255 + 1);
   localparam int PROD_W = SUM_W + RECIP_W;
   localparam logic [PROD_W:0] ROUND_PROD = (PROD_W + 1)'(1 << (FRAC_SHIFT - 1));
   localparam logic [GAIN_PROD_W:0] ROUND_GAIN = (GAIN_PROD_W + 1)'(1 << (FRAC_SHIFT - 1));

   logic [RECIP_W-1:0] recip_table [0:WinDepth];

   for (genvar g = 0; g <= WinDepth; g++) begin : g_recip
      localparam longint unsigned RecipValue =
         (g == 0) ? 0 : ((64'd1 << 24) + g - 1) / ((g == 0) ? 1 : g);
      assign recip_table[g] = RECIP_W'(RecipValue);
   end

   logic                     adv;
   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic [PROD_W-1:0]        s1_prod_ff, s1_prod_in;
   logic [PIXEL_W-1:0]       s1_pix_ff, s2_pix_ff, s3_pix_ff, s4_pix_ff;
   logic                     s1_done_ff, s2_done_ff, s3_done_ff, s4_done_ff;
   logic [PROD_W:0]          m_round;
   logic [MEAN_W-1:0]        s2_mean_ff;
   logic [GAIN_PROD_W-1:0]   s3_prod_ff, s3_prod_in;
   logic [THR_W-1:0]         s3_tl_ff, s3_tl_in;
   logic [GAIN_PROD_W:0]     gm_round;
   logic [THR_W-1:0]         s4_gm_ff, s4_tl_ff, s4_tl_min_ff, s4_tl_max_ff;
   logic [THR_W-1:0]         th_a, th_b, th_c, th_final, pix_scaled, ceil_scaled;
   logic                     bit_in;
   logic                     prev_ff, prev_in;
   logic                     out_bit_ff, out_done_ff;

   assign adv = !out_valid_ff || rsp_ready;
   assign job_pop = adv && job_valid;

   assign s1_prod_in = PROD_W'(job_sum) * PROD_W'(recip_table[job_n]);
   assign m_round = (PROD_W + 1)'(s1_prod_ff) + ROUND_PROD;
   assign s3_prod_in = GAIN_PROD_W'(cfg.gain_q16) * GAIN_PROD_W'(s2_mean_ff);
   assign s3_tl_in = THR_W'(s2_mean_ff) + THR_W'({cfg.low_offset, 8'd0});
   assign gm_round = (GAIN_PROD_W + 1)'(s3_prod_ff) + ROUND_GAIN;

   assign ceil_scaled = THR_W'({cfg.ceiling, 8'd0});
   assign pix_scaled = THR_W'({s4_pix_ff, 8'd0});
   assign th_a = (s4_gm_ff > s4_tl_min_ff) ? s4_gm_ff : s4_tl_min_ff;
   assign th_b = (th_a < s4_tl_max_ff) ? th_a : s4_tl_max_ff;
   assign th_c = (th_b < ceil_scaled) ? th_b : ceil_scaled;
   assign th_final = (th_c > s4_tl_ff) ? th_c : s4_tl_ff;

   always_comb begin
      if (pix_scaled > th_final) begin
         bit_in = 1'b1;
      end else if (pix_scaled < s4_tl_ff) begin
         bit_in = 1'b0;
      end else begin
         bit_in = prev_ff;
      end
      prev_in = prev_ff;
      if (adv && s4_valid_ff) begin
         prev_in = s4_done_ff ? 1'b0 : bit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_ff <= 1'b0;
      end else begin
         prev_ff <= prev_in;
         if (adv) begin
            s1_valid_ff <= job_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
            out_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod_ff <= s1_prod_in;
         s1_pix_ff <= job_pixel;
         s1_done_ff <= job_done;
         s2_mean_ff <= m_round[FRAC_SHIFT+MEAN_W-1:FRAC_SHIFT];
         s2_pix_ff <= s1_pix_ff;
         s2_done_ff <= s1_done_ff;
         s3_prod_ff <= s3_prod_in;
         s3_tl_ff <= s3_tl_in;
         s3_pix_ff <= s2_pix_ff;
         s3_done_ff <= s2_done_ff;
         s4_gm_ff <= gm_round[FRAC_SHIFT+THR_W-1:FRAC_SHIFT];
         s4_tl_ff <= s3_tl_ff;
         s4_tl_min_ff <= s3_tl_ff + THR_W'({cfg.min_rise, 8'd0});
         s4_tl_max_ff <= s3_tl_ff + THR_W'({cfg.max_rise, 8'd0});
         s4_pix_ff <= s3_pix_ff;
         s4_done_ff <= s3_done_ff;
         out_bit_ff <= bit_in;
         out_done_ff <= s4_done_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_mask_bit = out_bit_ff;
   assign rsp_row_done = out_done_ff;

endmodule

[rtl/row_adaptive_dual_threshold.sv]
// Top level of the row adaptive dual threshold binarizer with its register file.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_pixel_value[7:0], req_row_end
//   rsp       out        rsp_valid/rsp_ready  rsp_mask_bit, rsp_row_done
//   csr       in/out     APB, pready high     five registers at byte address 4*i
//
// One pixel is taken per cycle while a row streams and the job queue is not full.
// An item with req_row_end set holds the input off while the front end aligns and
// shifts the window out and queues the pending pixels of the row.
// Results leave through a five-stage stalling pipeline behind the job queue.
// Reset is synchronous and needs no clearing pass; a stalled output halts the pipeline
// and the job queue absorbs the front end until it fills.
`timescale 1ns / 1ps

module row_adaptive_dual_threshold
   import radt_pkg::*;
#(
   parameter int HALF_WINDOW = 12,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [PIXEL_W-1:0] req_pixel_value,
   input  logic               req_row_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_mask_bit,
   output logic               rsp_row_done,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int WinDepth = 2 * HALF_WINDOW + 1;
   localparam int CNT_W = $clog2(WinDepth + 1);
   localparam int SUM_W = $clog2(WinDepth * 255 + 1);
   localparam int JOB_W = SUM_W + CNT_W + PIXEL_W + 1;

   logic [PIXEL_W-1:0]     low_offset_ff;
   logic [GAIN_W-1:0]      gain_q16_ff;
   logic [PIXEL_W-1:0]     min_rise_ff;
   logic [PIXEL_W-1:0]     max_rise_ff;
   logic [PIXEL_W-1:0]     ceiling_ff;
   logic                   csr_write;
   logic [REG_INDEX_W-1:0] csr_index;
   cfg_type                cfg;

   logic                   queue_full;
   logic                   job_push;
   logic [SUM_W-1:0]       front_sum, back_sum;
   logic [CNT_W-1:0]       front_n, back_n;
   logic [PIXEL_W-1:0]     front_pixel, back_pixel;
   logic                   front_done, back_done;
   logic                   job_pop;
   logic                   job_valid;
   logic [JOB_W-1:0]       queue_out;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_index = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         low_offset_ff <= LOW_OFFSET_RESET;
         gain_q16_ff <= GAIN_Q16_RESET;
         min_rise_ff <= MIN_RISE_RESET;
         max_rise_ff <= MAX_RISE_RESET;
         ceiling_ff <= CEILING_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_LOW_OFFSET: low_offset_ff <= csr_pwdata[PIXEL_W-1:0];
            REG_GAIN_Q16: gain_q16_ff <= csr_pwdata[GAIN_W-1:0];
            REG_MIN_RISE: min_rise_ff <= csr_pwdata[PIXEL_W-1:0];
            REG_MAX_RISE: max_rise_ff <= csr_pwdata[PIXEL_W-1:0];
            REG_CEILING: ceiling_ff <= csr_pwdata[PIXEL_W-1:0];
            default: ceiling_ff <= ceiling_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_LOW_OFFSET: csr_prdata = 32'(low_offset_ff);
         REG_GAIN_Q16: csr_prdata = 32'(gain_q16_ff);
         REG_MIN_RISE: csr_prdata = 32'(min_rise_ff);
         REG_MAX_RISE: csr_prdata = 32'(max_rise_ff);
         REG_CEILING: csr_prdata = 32'(ceiling_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign cfg.low_offset = low_offset_ff;
   assign cfg.gain_q16 = gain_q16_ff;
   assign cfg.min_rise = min_rise_ff;
   assign cfg.max_rise = max_rise_ff;
   assign cfg.ceiling = ceiling_ff;

   radt_front #(
      .HALF_WINDOW(HALF_WINDOW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pixel_value(req_pixel_value),
      .req_row_end(req_row_end),
      .queue_full(queue_full),
      .job_push(job_push),
      .job_sum(front_sum),
      .job_n(front_n),
      .job_pixel(front_pixel),
      .job_done(front_done)
   );

   radt_queue #(
      .DEPTH(QUEUE_DEPTH),
      .DATA_W(JOB_W)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .push_data({front_sum, front_n, front_pixel, front_done}),
      .full(queue_full),
      .pop(job_pop),
      .pop_valid(job_valid),
      .pop_data(queue_out)
   );

   assign {back_sum, back_n, back_pixel, back_done} = queue_out;

   radt_back #(
      .HALF_WINDOW(HALF_WINDOW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .job_valid(job_valid),
      .job_sum(back_sum),
      .job_n(back_n),
      .job_pixel(back_pixel),
      .job_done(back_done),
      .job_pop(job_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_mask_bit(rsp_mask_bit),
      .rsp_row_done(rsp_row_done)
   );

endmodule
